[hw/rtl/tce_pkg.sv]
// Shared types and constants for the text console editor with undo.
// Used by tce_cell_mem, tce_undo_mem, tce_seq and the top level; no dependencies.
`default_nettype none

package tce_pkg;

    localparam int REGION_CELLS_DEF = 4096;
    localparam int ROW_WIDTH_DEF    = 80;
    localparam int SCREEN_CELLS_DEF = 2000;
    localparam int TAB_CELLS_DEF    = 4;
    localparam int UNDO_DEPTH_DEF   = 4096;

    localparam logic [7:0] CODE_BS       = 8'd8;
    localparam logic [7:0] CODE_TAB      = 8'd9;
    localparam logic [7:0] CODE_NL       = 8'd10;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7a;
    localparam logic [7:0] CHAR_UPPER_Z  = 8'h5a;
    localparam logic [7:0] DEFAULT_COLOR = 8'd7;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // byte address of the char_color register
    localparam logic ADDR_CHAR_COLOR = 1'b0;

    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_TAB  = 2'd1,
        MARK_NL   = 2'd2
    } mark_t;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  char_code;
        logic        ctrl_held;
        logic [11:0] cell_index;
    } in_t;

    typedef struct packed {
        logic [11:0] cursor_pos;
        logic [11:0] window_start;
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
        logic [12:0] undo_depth;
        logic        ignored;
    } out_t;

    typedef struct packed {
        logic rd;
        logic we_mark;
        logic we_data;
    } cell_ctl_t;

    typedef struct packed {
        logic rd;
        logic we;
    } undo_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/tce_cell_mem.sv]
// Cell store: mark, attribute and character of every console cell.
// Single port with a registered read; mark and data fields written separately.
`default_nettype none

module tce_cell_mem #(
    parameter int DEPTH = tce_pkg::REGION_CELLS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire tce_pkg::cell_ctl_t ctl,
    input  wire logic [AW-1:0]     addr,
    input  wire tce_pkg::mark_t    wr_mark,
    input  wire logic [7:0]        wr_char,
    input  wire logic [7:0]        wr_color,
    output logic [1:0]             rd_mark,
    output logic [7:0]             rd_char,
    output logic [7:0]             rd_color
);

    logic [17:0] mem [DEPTH];
    logic [17:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we_mark)
        begin
            mem[addr][17:16] <= wr_mark;
        end
        if (ctl.we_data)
        begin
            mem[addr][15:0] <= {wr_color, wr_char};
        end
        if (ctl.rd)
        begin
            q_reg <= mem[addr];
        end
    end

    assign rd_mark  = q_reg[17:16];
    assign rd_color = q_reg[15:8];
    assign rd_char  = q_reg[7:0];

endmodule

`default_nettype wire

[hw/rtl/tce_undo_mem.sv]
// Undo stack storage: one inverse-edit code per entry.
// Single port with a registered read; depends on tce_pkg.
`default_nettype none

module tce_undo_mem #(
    parameter int DEPTH = tce_pkg::UNDO_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               clk,
    input  wire tce_pkg::undo_ctl_t ctl,
    input  wire logic [AW-1:0]      addr,
    input  wire logic [7:0]         wdata,
    output logic [7:0]              rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            q_reg <= mem[addr];
        end
    end

    assign rdata = q_reg;

endmodule

`default_nettype wire

[hw/rtl/tce_seq.sv]
// Edit sequencer: walks the cell store and undo stack one access per cycle.
// Depends on tce_pkg; drives tce_cell_mem and tce_undo_mem.
`default_nettype none

module tce_seq #(
    parameter int REGION_CELLS = tce_pkg::REGION_CELLS_DEF,
    parameter int ROW_WIDTH    = tce_pkg::ROW_WIDTH_DEF,
    parameter int SCREEN_CELLS = tce_pkg::SCREEN_CELLS_DEF,
    parameter int TAB_CELLS    = tce_pkg::TAB_CELLS_DEF,
    parameter int UNDO_DEPTH   = tce_pkg::UNDO_DEPTH_DEF,
    parameter int CW           = $clog2(REGION_CELLS),
    parameter int UAW          = $clog2(UNDO_DEPTH)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire tce_pkg::in_t       item,
    input  wire logic [7:0]         char_color,
    output tce_pkg::cell_ctl_t      cell_ctl,
    output logic [CW-1:0]           cell_addr,
    output tce_pkg::mark_t          cell_wmark,
    output logic [7:0]              cell_wchar,
    output logic [7:0]              cell_wcolor,
    input  wire logic [1:0]         cell_rmark,
    input  wire logic [7:0]         cell_rchar,
    input  wire logic [7:0]         cell_rcolor,
    output tce_pkg::undo_ctl_t      undo_ctl,
    output logic [UAW-1:0]          undo_addr,
    output logic [7:0]              undo_wdata,
    input  wire logic [7:0]         undo_rdata,
    output logic                    done,
    output tce_pkg::out_t           result
);

    localparam int COLW = $clog2(ROW_WIDTH);
    localparam int UW   = $clog2(UNDO_DEPTH + 1);
    localparam int TCW  = $clog2(TAB_CELLS + 1);

    localparam logic [COLW-1:0] COL_LAST = COLW'(ROW_WIDTH - 1);
    localparam logic [CW-1:0]   CELL_LAST = CW'(REGION_CELLS - 1);
    localparam logic [TCW-1:0]  TAB_LAST = TCW'(TAB_CELLS - 1);

    typedef enum logic [14:0] {
        S_CLEAR     = 15'b000000000000001,
        S_IDLE      = 15'b000000000000010,
        S_RD_WAIT   = 15'b000000000000100,
        S_DISPATCH  = 15'b000000000001000,
        S_UNDO_WAIT = 15'b000000000010000,
        S_TAB_FWD   = 15'b000000000100000,
        S_NL_FWD    = 15'b000000001000000,
        S_BS_WAIT   = 15'b000000010000000,
        S_BS_TAB    = 15'b000000100000000,
        S_SRCH_RD   = 15'b000001000000000,
        S_SRCH_CHK  = 15'b000010000000000,
        S_NL_BLANK  = 15'b000100000000000,
        S_SCROLL    = 15'b001000000000000,
        S_DONE      = 15'b010000000000000,
        S_SPARE     = 15'b100000000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cursor_reg, cursor_next;
    logic [COLW-1:0] col_reg, col_next;
    logic [CW-1:0]   view_reg, view_next;
    logic [UW-1:0]   ucnt_reg, ucnt_next;
    logic [7:0]      ch_reg, ch_next;
    logic            ctrl_reg, ctrl_next;
    logic            replay_reg, replay_next;
    logic            ign_reg, ign_next;
    logic [7:0]      rdc_reg, rdc_next;
    logic [7:0]      rdcol_reg, rdcol_next;
    logic [CW-1:0]   s_reg, s_next;
    logic [COLW-1:0] scol_reg, scol_next;
    logic [TCW-1:0]  cnt_reg, cnt_next;
    logic            first_reg, first_next;
    logic [CW-1:0]   clr_reg, clr_next;

    logic            push_req;
    logic [7:0]      push_code;
    logic            pop_req;
    logic [CW-1:0]   pos;
    logic [COLW-1:0] col_inc, col_dec;
    logic            room_char, room_tab, room_nl;
    logic            is_undo;
    logic            rd_in_region;
    logic            scroll_go;

    assign pos     = cursor_reg - CW'(1);
    assign col_inc = (col_reg == COL_LAST) ? '0 : col_reg + COLW'(1);
    assign col_dec = (col_reg == '0) ? COL_LAST : col_reg - COLW'(1);

    assign room_char = 32'(cursor_reg) < 32'(REGION_CELLS - 1);
    assign room_tab  = 32'(cursor_reg) < 32'(REGION_CELLS - TAB_CELLS);
    assign room_nl   = 32'(cursor_reg) < 32'(REGION_CELLS - ROW_WIDTH);
    assign is_undo   = ((ch_reg == tce_pkg::CHAR_LOWER_Z) || (ch_reg == tce_pkg::CHAR_UPPER_Z))
                       && ctrl_reg && !replay_reg;
    assign rd_in_region = 32'(item.cell_index) < 32'(REGION_CELLS);
    assign scroll_go = (32'(cursor_reg) >= 32'(view_reg) + 32'(SCREEN_CELLS))
                       && (32'(view_reg) + 32'(SCREEN_CELLS) < 32'(REGION_CELLS));

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        col_next    = col_reg;
        view_next   = view_reg;
        ucnt_next   = ucnt_reg;
        ch_next     = ch_reg;
        ctrl_next   = ctrl_reg;
        replay_next = replay_reg;
        ign_next    = ign_reg;
        rdc_next    = rdc_reg;
        rdcol_next  = rdcol_reg;
        s_next      = s_reg;
        scol_next   = scol_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        clr_next    = clr_reg;

        cell_ctl    = '0;
        cell_addr   = cursor_reg;
        cell_wmark  = tce_pkg::MARK_NONE;
        cell_wchar  = 8'd0;
        cell_wcolor = char_color;
        push_req    = 1'b0;
        push_code   = tce_pkg::CODE_BS;
        pop_req     = 1'b0;
        done        = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cell_ctl.we_mark = 1'b1;
                cell_ctl.we_data = 1'b1;
                cell_addr        = clr_reg;
                cell_wcolor      = tce_pkg::DEFAULT_COLOR;
                clr_next         = clr_reg + CW'(1);
                if (clr_reg == CELL_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ch_next     = item.char_code;
                    ctrl_next   = item.ctrl_held;
                    replay_next = 1'b0;
                    ign_next    = 1'b0;
                    rdc_next    = 8'd0;
                    rdcol_next  = 8'd0;
                    if (item.opcode == tce_pkg::OP_READ)
                    begin
                        cell_ctl.rd = rd_in_region;
                        cell_addr   = CW'(item.cell_index);
                        first_next  = rd_in_region;
                        state_next  = S_RD_WAIT;
                    end
                    else
                    begin
                        state_next = S_DISPATCH;
                    end
                end
            end
            S_RD_WAIT:
            begin
                if (first_reg)
                begin
                    rdc_next   = cell_rchar;
                    rdcol_next = cell_rcolor;
                end
                state_next = S_DONE;
            end
            S_DISPATCH:
            begin
                priority if (ch_reg == tce_pkg::CODE_TAB)
                begin
                    if (room_tab)
                    begin
                        cnt_next   = '0;
                        state_next = S_TAB_FWD;
                    end
                    else
                    begin
                        ign_next   = !replay_reg;
                        state_next = S_SCROLL;
                    end
                end
                else if (ch_reg == tce_pkg::CODE_NL)
                begin
                    if (room_nl)
                    begin
                        first_next = 1'b1;
                        state_next = S_NL_FWD;
                    end
                    else
                    begin
                        ign_next   = !replay_reg;
                        state_next = S_SCROLL;
                    end
                end
                else if (ch_reg == tce_pkg::CODE_BS)
                begin
                    if (cursor_reg == '0)
                    begin
                        ign_next   = !replay_reg;
                        state_next = S_SCROLL;
                    end
                    else
                    begin
                        cell_ctl.rd = 1'b1;
                        cell_addr   = pos;
                        state_next  = S_BS_WAIT;
                    end
                end
                else if (is_undo)
                begin
                    if (ucnt_reg == '0)
                    begin
                        ign_next   = 1'b1;
                        state_next = S_SCROLL;
                    end
                    else
                    begin
                        pop_req    = 1'b1;
                        ucnt_next  = ucnt_reg - UW'(1);
                        state_next = S_UNDO_WAIT;
                    end
                end
                else
                begin
                    if (room_char)
                    begin
                        cell_ctl.we_mark = 1'b1;
                        cell_ctl.we_data = 1'b1;
                        cell_wchar       = ch_reg;
                        cursor_next      = cursor_reg + CW'(1);
                        col_next         = col_inc;
                        push_req         = 1'b1;
                    end
                    else
                    begin
                        ign_next = !replay_reg;
                    end
                    state_next = S_SCROLL;
                end
            end
            S_UNDO_WAIT:
            begin
                // replay the popped code as an unrecorded edit
                ch_next     = undo_rdata;
                ctrl_next   = 1'b0;
                replay_next = 1'b1;
                state_next  = S_DISPATCH;
            end
            S_TAB_FWD:
            begin
                cell_ctl.we_mark = 1'b1;
                cell_ctl.we_data = 1'b1;
                cell_wmark       = tce_pkg::MARK_TAB;
                cursor_next      = cursor_reg + CW'(1);
                col_next         = col_inc;
                cnt_next         = cnt_reg + TCW'(1);
                if (cnt_reg == TAB_LAST)
                begin
                    push_req   = 1'b1;
                    state_next = S_SCROLL;
                end
            end
            S_NL_FWD:
            begin
                // mark start and row end, clear marks between; data untouched
                cell_ctl.we_mark = 1'b1;
                cell_wmark       = (first_reg || (col_reg == COL_LAST)) ?
                                   tce_pkg::MARK_NL : tce_pkg::MARK_NONE;
                first_next       = 1'b0;
                cursor_next      = cursor_reg + CW'(1);
                col_next         = col_inc;
                if (col_reg == COL_LAST)
                begin
                    push_req   = 1'b1;
                    state_next = S_SCROLL;
                end
            end
            S_BS_WAIT:
            begin
                priority if (cell_rmark == tce_pkg::MARK_TAB)
                begin
                    cnt_next   = '0;
                    state_next = S_BS_TAB;
                end
                else if (cell_rmark == tce_pkg::MARK_NL)
                begin
                    s_next     = pos;
                    scol_next  = col_dec;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    cell_ctl.we_data = 1'b1;
                    cell_addr        = pos;
                    cursor_next      = pos;
                    col_next         = col_dec;
                    push_req         = 1'b1;
                    push_code        = cell_rchar;
                    state_next       = S_SCROLL;
                end
            end
            S_BS_TAB:
            begin
                if (cursor_reg == '0)
                begin
                    push_req   = 1'b1;
                    push_code  = tce_pkg::CODE_TAB;
                    state_next = S_SCROLL;
                end
                else
                begin
                    cell_ctl.we_mark = 1'b1;
                    cell_ctl.we_data = 1'b1;
                    cell_addr        = pos;
                    cursor_next      = pos;
                    col_next         = col_dec;
                    cnt_next         = cnt_reg + TCW'(1);
                    if (cnt_reg == TAB_LAST)
                    begin
                        push_req   = 1'b1;
                        push_code  = tce_pkg::CODE_TAB;
                        state_next = S_SCROLL;
                    end
                end
            end
            S_SRCH_RD:
            begin
                if (scol_reg == '0)
                begin
                    // no start mark in this row: back up one cell only
                    s_next     = pos;
                    state_next = S_NL_BLANK;
                end
                else
                begin
                    cell_ctl.rd = 1'b1;
                    cell_addr   = s_reg - CW'(1);
                    s_next      = s_reg - CW'(1);
                    scol_next   = scol_reg - COLW'(1);
                    state_next  = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                state_next = (cell_rmark == tce_pkg::MARK_NL) ? S_NL_BLANK : S_SRCH_RD;
            end
            S_NL_BLANK:
            begin
                cell_ctl.we_mark = 1'b1;
                cell_ctl.we_data = (pos != s_reg);
                cell_addr        = pos;
                cursor_next      = pos;
                col_next         = col_dec;
                if (pos == s_reg)
                begin
                    push_req   = 1'b1;
                    push_code  = tce_pkg::CODE_NL;
                    state_next = S_SCROLL;
                end
            end
            S_SCROLL:
            begin
                if (scroll_go)
                begin
                    view_next = view_reg + CW'(ROW_WIDTH);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // record the inverse edit; drop it on replay or a full stack
        undo_ctl   = '0;
        undo_addr  = UAW'(ucnt_reg);
        undo_wdata = push_code;
        if (pop_req)
        begin
            undo_ctl.rd = 1'b1;
            undo_addr   = UAW'(ucnt_reg - UW'(1));
        end
        else if (push_req && !replay_reg && (32'(ucnt_reg) < 32'(UNDO_DEPTH)))
        begin
            undo_ctl.we = 1'b1;
            ucnt_next   = ucnt_reg + UW'(1);
        end
    end

    always_comb
    begin
        result.cursor_pos   = 12'(cursor_reg);
        result.window_start = 12'(view_reg);
        result.cell_char    = rdc_reg;
        result.cell_color   = rdcol_reg;
        result.undo_depth   = 13'(ucnt_reg);
        result.ignored      = ign_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cursor_reg <= '0;
            col_reg    <= '0;
            view_reg   <= '0;
            ucnt_reg   <= '0;
            clr_reg    <= '0;
            replay_reg <= 1'b0;
            ign_reg    <= 1'b0;
            first_reg  <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            view_reg   <= view_next;
            ucnt_reg   <= ucnt_next;
            clr_reg    <= clr_next;
            replay_reg <= replay_next;
            ign_reg    <= ign_next;
            first_reg  <= first_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        ctrl_reg  <= ctrl_next;
        rdc_reg   <= rdc_next;
        rdcol_reg <= rdcol_next;
        s_reg     <= s_next;
        scol_reg  <= scol_next;
    end

endmodule

`default_nettype wire

[hw/rtl/text_console_editor_with_undo.sv]
// Top level of the text console editor with undo: register port and wiring.
// Depends on tce_pkg, tce_cell_mem, tce_undo_mem and tce_seq.
`default_nettype none

// Items are taken with start while busy is low; each item yields one result on
// result, marked by a one-cycle done strobe that cannot be held off. After reset
// the cell store is swept once (busy high) before the first item. An edit makes
// at most one cell-store access per cycle; a tab walks TAB_CELLS cells, a
// newline walks to the row end, and a newline backspace runs a row search and a
// blank walk through the single memory port. Undo adds a stack read. char_color
// sits at byte address 0 on the APB port.
module text_console_editor_with_undo #(
    parameter int REGION_CELLS = tce_pkg::REGION_CELLS_DEF,
    parameter int ROW_WIDTH    = tce_pkg::ROW_WIDTH_DEF,
    parameter int SCREEN_CELLS = tce_pkg::SCREEN_CELLS_DEF,
    parameter int TAB_CELLS    = tce_pkg::TAB_CELLS_DEF,
    parameter int UNDO_DEPTH   = tce_pkg::UNDO_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire tce_pkg::in_t  item,
    output logic               done,
    output tce_pkg::out_t      result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic          paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW  = $clog2(REGION_CELLS);
    localparam int UAW = $clog2(UNDO_DEPTH);

    logic [7:0]         color_reg;
    tce_pkg::cell_ctl_t cell_ctl;
    logic [CW-1:0]      cell_addr;
    tce_pkg::mark_t     cell_wmark;
    logic [7:0]         cell_wchar;
    logic [7:0]         cell_wcolor;
    logic [1:0]         cell_rmark;
    logic [7:0]         cell_rchar;
    logic [7:0]         cell_rcolor;
    tce_pkg::undo_ctl_t undo_ctl;
    logic [UAW-1:0]     undo_addr;
    logic [7:0]         undo_wdata;
    logic [7:0]         undo_rdata;

    assign pready = 1'b1;
    assign prdata = {24'd0, color_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= tce_pkg::DEFAULT_COLOR;
        end
        else if (psel && penable && pwrite && (paddr == tce_pkg::ADDR_CHAR_COLOR))
        begin
            color_reg <= pwdata[7:0];
        end
    end

    tce_cell_mem #(
        .DEPTH (REGION_CELLS),
        .AW    (CW)
    ) u_cell_mem (
        .clk      (clk),
        .ctl      (cell_ctl),
        .addr     (cell_addr),
        .wr_mark  (cell_wmark),
        .wr_char  (cell_wchar),
        .wr_color (cell_wcolor),
        .rd_mark  (cell_rmark),
        .rd_char  (cell_rchar),
        .rd_color (cell_rcolor)
    );

    tce_undo_mem #(
        .DEPTH (UNDO_DEPTH),
        .AW    (UAW)
    ) u_undo_mem (
        .clk   (clk),
        .ctl   (undo_ctl),
        .addr  (undo_addr),
        .wdata (undo_wdata),
        .rdata (undo_rdata)
    );

    tce_seq #(
        .REGION_CELLS (REGION_CELLS),
        .ROW_WIDTH    (ROW_WIDTH),
        .SCREEN_CELLS (SCREEN_CELLS),
        .TAB_CELLS    (TAB_CELLS),
        .UNDO_DEPTH   (UNDO_DEPTH),
        .CW           (CW),
        .UAW          (UAW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .char_color  (color_reg),
        .cell_ctl    (cell_ctl),
        .cell_addr   (cell_addr),
        .cell_wmark  (cell_wmark),
        .cell_wchar  (cell_wchar),
        .cell_wcolor (cell_wcolor),
        .cell_rmark  (cell_rmark),
        .cell_rchar  (cell_rchar),
        .cell_rcolor (cell_rcolor),
        .undo_ctl    (undo_ctl),
        .undo_addr   (undo_addr),
        .undo_wdata  (undo_wdata),
        .undo_rdata  (undo_rdata),
        .done        (done),
        .result      (result)
    );

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for text_console_editor_with_undo: directed table, then random keys.
// Depends on tce_pkg and the top level; the predictor keeps its own copy of the cell store.
`timescale 1ns / 100ps

module tb;
    import tce_pkg::*;

    localparam int REGION  = REGION_CELLS_DEF;
    localparam int ROW     = ROW_WIDTH_DEF;
    localparam int SCREEN  = SCREEN_CELLS_DEF;
    localparam int TABW    = TAB_CELLS_DEF;
    localparam int STACK   = UNDO_DEPTH_DEF;
    localparam int WD_LIMIT = 30000;

    typedef enum int { MIX_TYPING, MIX_LINES, MIX_ERASE } mix_t;

    typedef struct {
        in_t  it;
        bit   known;
        out_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_t         item;
    logic        done;
    out_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // shadow console state
    logic [7:0]  sh_char [REGION];
    logic [7:0]  sh_color [REGION];
    mark_t       sh_mark [REGION];
    logic [7:0]  sh_undo [STACK];
    int          sh_depth;
    int          sh_cursor;
    int          sh_view;
    logic [7:0]  sh_attr;

    out_t        pending_q [$];
    bit          known_q [$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          n_ignored;
    int          idle_cnt;
    bit          allow_gaps;

    text_console_editor_with_undo uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void blank(int i);
        sh_char[i]  = 8'd0;
        sh_color[i] = sh_attr;
    endfunction

    function automatic void record(logic [7:0] code, bit replay);
        if (!replay && sh_depth < STACK)
        begin
            sh_undo[sh_depth] = code;
            sh_depth++;
        end
    endfunction

    function automatic bit erase_back(bit replay);
        int  pos;
        int  s;
        int  base;
        bit  found;
        if (sh_cursor == 0)
            return 1'b0;
        pos = sh_cursor - 1;
        if (sh_mark[pos] == MARK_TAB)
        begin
            for (int i = 0; i < TABW && sh_cursor > 0; i++)
            begin
                sh_cursor--;
                sh_mark[sh_cursor] = MARK_NONE;
                blank(sh_cursor);
            end
            record(CODE_TAB, replay);
        end
        else if (sh_mark[pos] == MARK_NL)
        begin
            base  = pos - (pos % ROW);
            found = 1'b0;
            s     = pos;
            while (s > base)
            begin
                s--;
                if (sh_mark[s] == MARK_NL)
                begin
                    found = 1'b1;
                    break;
                end
            end
            if (found)
            begin
                for (int i = pos; i > s; i--)
                begin
                    sh_mark[i] = MARK_NONE;
                    blank(i);
                end
                sh_mark[s] = MARK_NONE;
                sh_cursor  = s;
            end
            else
            begin
                // single-cell newline: back up one cell only
                sh_mark[pos] = MARK_NONE;
                sh_cursor    = pos;
            end
            record(CODE_NL, replay);
        end
        else
        begin
            record(sh_char[pos], replay);
            blank(pos);
            sh_cursor = pos;
        end
        return 1'b1;
    endfunction

    function automatic bit key_edit(logic [7:0] ch, bit ctrl, bit replay);
        int          last;
        logic [7:0]  code;
        bit          dummy;
        if (ch == CODE_TAB)
        begin
            if (sh_cursor >= REGION - TABW)
                return 1'b0;
            for (int i = 0; i < TABW; i++)
            begin
                blank(sh_cursor + i);
                sh_mark[sh_cursor + i] = MARK_TAB;
            end
            sh_cursor += TABW;
            record(CODE_BS, replay);
            return 1'b1;
        end
        if (ch == CODE_NL)
        begin
            if (sh_cursor >= REGION - ROW)
                return 1'b0;
            last = ROW * (sh_cursor / ROW + 1) - 1;
            sh_mark[sh_cursor] = MARK_NL;
            for (int i = sh_cursor + 1; i < last; i++)
                sh_mark[i] = MARK_NONE;
            sh_mark[last] = MARK_NL;
            sh_cursor = last + 1;
            record(CODE_BS, replay);
            return 1'b1;
        end
        if (ch == CODE_BS)
            return erase_back(replay);
        if ((ch == CHAR_LOWER_Z || ch == CHAR_UPPER_Z) && ctrl && !replay)
        begin
            if (sh_depth == 0)
                return 1'b0;
            sh_depth--;
            code  = sh_undo[sh_depth];
            dummy = key_edit(code, 1'b0, 1'b1);
            return 1'b1;
        end
        if (sh_cursor >= REGION - 1)
            return 1'b0;
        sh_char[sh_cursor]  = ch;
        sh_color[sh_cursor] = sh_attr;
        sh_mark[sh_cursor]  = MARK_NONE;
        sh_cursor++;
        record(CODE_BS, replay);
        return 1'b1;
    endfunction

    function automatic out_t console_step(in_t it);
        out_t o;
        o = '0;
        if (it.opcode == OP_READ)
        begin
            if (it.cell_index < REGION)
            begin
                o.cell_char  = sh_char[it.cell_index];
                o.cell_color = sh_color[it.cell_index];
            end
        end
        else
        begin
            o.ignored = !key_edit(it.char_code, it.ctrl_held, 1'b0);
            while (sh_cursor >= sh_view + SCREEN && sh_view + SCREEN < REGION)
                sh_view += ROW;
        end
        o.cursor_pos   = sh_cursor[11:0];
        o.window_start = sh_view[11:0];
        o.undo_depth   = sh_depth[12:0];
        return o;
    endfunction

    // results cannot be held off: sample at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with none expected: %p", $time, result);
                errors++;
            end
            else
            begin
                out_t w;
                w = pending_q.pop_front();
                void'(known_q.pop_front());
                n_checked++;
                if (w.ignored)
                    n_ignored++;
                if (result.cursor_pos !== w.cursor_pos)
                    $display("%0t: cursor_pos exp %0d got %0d", $time, w.cursor_pos,
                             result.cursor_pos);
                if (result.window_start !== w.window_start)
                    $display("%0t: window_start exp %0d got %0d", $time, w.window_start,
                             result.window_start);
                if (result.cell_char !== w.cell_char)
                    $display("%0t: cell_char exp %0h got %0h", $time, w.cell_char,
                             result.cell_char);
                if (result.cell_color !== w.cell_color)
                    $display("%0t: cell_color exp %0h got %0h", $time, w.cell_color,
                             result.cell_color);
                if (result.undo_depth !== w.undo_depth)
                    $display("%0t: undo_depth exp %0d got %0d", $time, w.undo_depth,
                             result.undo_depth);
                if (result.ignored !== w.ignored)
                    $display("%0t: ignored exp %0b got %0b", $time, w.ignored,
                             result.ignored);
                if (result !== w)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // call at a rising edge; returns at the accepting rising edge, or after a random gap when allowed
    task automatic send(in_t it, bit known, out_t want);
        out_t p;
        item  <= it;
        start <= 1'b1;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        p = console_step(it);
        if (known && p !== want)
        begin
            $display("%0t: table row disagrees: exp %p predicted %p", $time, want, p);
            errors++;
        end
        pending_q.push_back(p);
        known_q.push_back(known);
        n_sent++;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic key(in_t it);
        send(it, 1'b0, '0);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_color(logic [7:0] c);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CHAR_COLOR;
        pwdata  <= {24'd0, c};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sh_attr = c;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[7:0] !== c)
        begin
            $display("%0t: char_color readback exp %0h got %0h", $time, c, prdata[7:0]);
            errors++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic in_t mk(logic op, logic [7:0] ch, logic ctrl, logic [11:0] idx);
        in_t it;
        it.opcode     = op;
        it.char_code  = ch;
        it.ctrl_held  = ctrl;
        it.cell_index = idx;
        return it;
    endfunction

    function automatic in_t pick(mix_t mix);
        int r;
        int lo;
        int hi;
        in_t it;
        it = mk(OP_KEY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                12'($urandom_range(0, REGION - 1)));
        r = $urandom_range(0, 99);
        if (mix == MIX_LINES)
            r = (r < 45) ? 10 : r;
        else if (mix == MIX_ERASE)
            r = (r < 40) ? 15 : (r < 65) ? 25 : r;
        if (r < 8)
            it.char_code = CODE_TAB;
        else if (r < 12)
            it.char_code = CODE_NL;
        else if (r < 22)
            it.char_code = CODE_BS;
        else if (r < 28)
        begin
            it.char_code = $urandom_range(0, 1) ? CHAR_LOWER_Z : CHAR_UPPER_Z;
            it.ctrl_held = 1'b1;
        end
        else if (r < 40)
        begin
            it.opcode = OP_READ;
            if ($urandom_range(0, 1))
            begin
                lo = (sh_cursor > 90) ? sh_cursor - 90 : 0;
                hi = (sh_cursor + 4 < REGION) ? sh_cursor + 4 : REGION - 1;
                it.cell_index = 12'($urandom_range(lo, hi));
            end
        end
        return it;
    endfunction

    task automatic random_run(int count);
        int  left;
        int  burst;
        mix_t mix;
        left = count;
        while (left > 0)
        begin
            mix   = mix_t'($urandom_range(0, 2));
            burst = $urandom_range(5, 40);
            for (int i = 0; i < burst && left > 0; i++, left--)
                key(pick(mix));
            // now and then fill a row to its last cell, put a one-cell newline there, read it back, erase it and undo
            if ($urandom_range(0, 5) == 0 && sh_cursor < REGION - 2 * ROW)
            begin
                while (sh_cursor % ROW != ROW - 1)
                begin
                    key(mk(OP_KEY, 8'($urandom_range(32, 126)), 1'b0, '0));
                    left--;
                end
                key(mk(OP_KEY, CODE_NL, 1'b0, '0));
                key(mk(OP_READ, 8'd0, 1'b0, 12'(sh_cursor - 1)));
                key(mk(OP_KEY, CODE_BS, 1'b0, '0));
                key(mk(OP_KEY, CHAR_LOWER_Z, 1'b1, '0));
                left -= 4;
            end
        end
    endtask

    // run the cursor into the end of the region and hit every out-of-room case
    task automatic hit_region_end();
        while (sh_cursor < REGION - ROW)
            key(mk(OP_KEY, CODE_NL, 1'b0, '0));
        key(mk(OP_KEY, CODE_NL, 1'b0, '0));
        while (sh_cursor < REGION - TABW)
            key(mk(OP_KEY, 8'($urandom_range(0, 255)), 1'b0, '0));
        key(mk(OP_KEY, CODE_TAB, 1'b0, '0));
        while (sh_cursor < REGION - 1)
            key(mk(OP_KEY, 8'hff, 1'b0, '0));
        key(mk(OP_KEY, 8'h41, 1'b0, '0));
        key(mk(OP_READ, 8'd0, 1'b0, 12'(REGION - 2)));
        key(mk(OP_READ, 8'd0, 1'b0, 12'(REGION - 1)));
        key(mk(OP_KEY, CODE_BS, 1'b0, '0));
        key(mk(OP_KEY, CHAR_UPPER_Z, 1'b1, '0));
    endtask

    row_t table_rows [$];

    task automatic add_row(in_t it, bit known, out_t want);
        row_t r;
        r.it    = it;
        r.known = known;
        r.want  = want;
        table_rows.push_back(r);
    endtask

    function automatic out_t idle_out(logic [7:0] ch, logic [7:0] col, bit ign);
        out_t o;
        o            = '0;
        o.cell_char  = ch;
        o.cell_color = col;
        o.ignored    = ign;
        return o;
    endfunction

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = 1'b0;
        pwdata     = '0;
        errors     = 0;
        n_sent     = 0;
        n_checked  = 0;
        n_ignored  = 0;
        idle_cnt   = 0;
        allow_gaps = 1'b0;
        sh_attr    = DEFAULT_COLOR;
        sh_depth   = 0;
        sh_cursor  = 0;
        sh_view    = 0;
        for (int i = 0; i < REGION; i++)
        begin
            sh_char[i]  = 8'd0;
            sh_color[i] = DEFAULT_COLOR;
            sh_mark[i]  = MARK_NONE;
        end

        // fresh console: blank reads, nothing to erase, nothing to undo
        add_row(mk(OP_READ, 8'd0, 1'b0, 12'd0), 1'b1, idle_out(8'd0, DEFAULT_COLOR, 1'b0));
        add_row(mk(OP_READ, 8'hff, 1'b1, 12'hfff), 1'b1,
                idle_out(8'd0, DEFAULT_COLOR, 1'b0));
        add_row(mk(OP_KEY, CODE_BS, 1'b0, 12'd0), 1'b1, idle_out(8'd0, 8'd0, 1'b1));
        add_row(mk(OP_KEY, CHAR_LOWER_Z, 1'b1, 12'd0), 1'b1, idle_out(8'd0, 8'd0, 1'b1));
        add_row(mk(OP_KEY, CHAR_UPPER_Z, 1'b1, 12'hfff), 1'b1, idle_out(8'd0, 8'd0, 1'b1));
        // plain keys, extremes, z without ctrl, tab, newline, erase and undo of the last three
        add_row(mk(OP_KEY, 8'h00, 1'b0, '0), 1'b0, '0);
        add_row(mk(OP_KEY, 8'hff, 1'b1, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CHAR_LOWER_Z, 1'b0, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CODE_TAB, 1'b0, '0), 1'b0, '0);
        add_row(mk(OP_READ, 8'd0, 1'b0, 12'd4), 1'b0, '0);
        add_row(mk(OP_KEY, CODE_NL, 1'b1, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CODE_BS, 1'b0, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CODE_BS, 1'b0, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CODE_BS, 1'b0, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CHAR_LOWER_Z, 1'b1, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CHAR_UPPER_Z, 1'b1, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CHAR_LOWER_Z, 1'b1, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CODE_NL, 1'b0, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CODE_NL, 1'b0, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CODE_BS, 1'b0, '0), 1'b0, '0);
        add_row(mk(OP_KEY, CHAR_UPPER_Z, 1'b1, '0), 1'b0, '0);
        add_row(mk(OP_READ, 8'd0, 1'b0, 12'd2), 1'b0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send(table_rows[i].it, table_rows[i].known, table_rows[i].want);

        drain();
        set_color(8'h00);
        allow_gaps = 1'b1;
        random_run(400);

        // hold the sender until the block has answered everything
        drain();
        set_color(8'hff);
        random_run(350);

        drain();
        set_color(8'($urandom_range(1, 254)));
        hit_region_end();
        random_run(150);

        drain();
        set_color(DEFAULT_COLOR);
        allow_gaps = 1'b0;
        random_run(300);

        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Covered %0d items (%0d checked, %0d ignored), four color settings,",
                 n_sent, n_checked, n_ignored);
        $display("cursor runs to the region end, tab/newline erase and undo replays.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
